### rtl/core/hrr_pkg.sv
package hrr_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned CoarseW = 8;
  localparam int unsigned AccW    = 16;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned HistD   = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_FAULT_LOW   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FAULT_HIGH  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FAULT_COUNT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RISE_ONE    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RISE_TWO    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FIXED_HEAT  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PERIOD      = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MIN_DROP    = 3'd7;

  // alarm level codes
  localparam logic [LevelW-1:0] LVL_FAULT  = 3'd0;
  localparam logic [LevelW-1:0] LVL_NORMAL = 3'd1;
  localparam logic [LevelW-1:0] LVL_RISE1  = 3'd2;
  localparam logic [LevelW-1:0] LVL_RISE2  = 3'd3;
  localparam logic [LevelW-1:0] LVL_FIXED  = 3'd4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_SEED   = 1'b1;

  localparam logic [3:0]        QuietTicks = 4'd3;
  localparam logic [3:0]        QuietPark  = 4'd10;
  localparam logic [CoarseW-1:0] DropDouble = 8'd8;
  localparam logic [CoarseW-1:0] DropTriple = 8'd16;

  typedef struct packed {
    logic               command;
    logic [SampleW-1:0] adc_sample;
    logic [SampleW-1:0] average_value;
    logic               timer_due;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] alarm_level;
    logic              sensor_fault;
    logic [AccW-1:0]   rise_total;
  } out_item_t;

  typedef struct packed {
    logic [SampleW-1:0] fault_low_limit;
    logic [SampleW-1:0] fault_high_limit;
    logic [7:0]         fault_count_limit;
    logic [AccW-1:0]    rise_stage_one_limit;
    logic [AccW-1:0]    rise_stage_two_limit;
    logic [SampleW-1:0] fixed_heat_limit;
    logic [3:0]         history_period;
    logic [7:0]         minimum_drop;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    fault_low_limit:      10'd5,
    fault_high_limit:     10'd1000,
    fault_count_limit:    8'd9,
    rise_stage_one_limit: 16'd375,
    rise_stage_two_limit: 16'd450,
    fixed_heat_limit:     10'd382,
    history_period:       4'd5,
    minimum_drop:         8'd2
  };

endpackage

### rtl/core/hrr_eval.sv
module hrr_eval import hrr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  logic [CoarseW-1:0] hist_q [HistD];
  logic [CoarseW-1:0] hist_d [HistD];
  logic [3:0]         tick_q, tick_d;
  logic [3:0]         quiet_q, quiet_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [7:0]         bad_q, bad_d;
  logic               fault_q, fault_d;
  logic [LevelW-1:0]  level_q, level_d;

  logic [CoarseW-1:0] coarse;
  logic [CoarseW-1:0] oldest;
  logic [CoarseW-1:0] drop;
  logic [9:0]         amount;
  logic [AccW:0]      sum;
  logic [3:0]         tick_inc;
  logic [3:0]         quiet_tmp;
  logic [AccW-1:0]    acc_tmp;
  logic               shift;
  logic               bad;
  logic               counted;

  assign coarse   = item_i.adc_sample[SampleW-1:2];
  assign tick_inc = (tick_q == 4'hF) ? tick_q : tick_q + 4'd1;
  assign shift    = tick_inc >= cfg_i.history_period;
  // after a shift the old slot two becomes the oldest
  assign oldest   = shift ? hist_q[2] : hist_q[3];
  assign drop     = oldest - coarse;
  assign counted  = (oldest > coarse) && (drop >= cfg_i.minimum_drop);
  assign amount   = {2'b00, drop}
                  + ((drop >= DropDouble) ? {2'b00, drop} : 10'd0)
                  + ((drop >= DropTriple) ? {2'b00, drop} : 10'd0);
  assign sum      = {1'b0, acc_q} + {{(AccW-9){1'b0}}, amount};
  assign bad      = (item_i.adc_sample < cfg_i.fault_low_limit) ||
                    (item_i.adc_sample > cfg_i.fault_high_limit);

  always_comb begin
    hist_d    = hist_q;
    tick_d    = tick_q;
    quiet_d   = quiet_q;
    acc_d     = acc_q;
    bad_d     = bad_q;
    fault_d   = fault_q;
    level_d   = level_q;
    quiet_tmp = quiet_q;
    acc_tmp   = acc_q;
    if (item_i.command == CMD_SEED) begin
      for (int i = 0; i < HistD; i++) begin
        hist_d[i] = item_i.average_value[SampleW-1:2];
      end
    end else begin
      if (bad) begin
        bad_d = (bad_q == 8'hFF) ? bad_q : bad_q + 8'd1;
        if (bad_d > cfg_i.fault_count_limit) begin
          fault_d = 1'b1;
        end
      end else begin
        bad_d   = '0;
        fault_d = 1'b0;
      end
      if (item_i.timer_due) begin
        tick_d = tick_inc;
        if (shift) begin
          tick_d    = '0;
          hist_d[3] = hist_q[2];
          hist_d[2] = hist_q[1];
          hist_d[1] = hist_q[0];
        end
        hist_d[0] = coarse;
        if (counted) begin
          quiet_tmp = '0;
          acc_tmp   = sum[AccW] ? {AccW{1'b1}} : sum[AccW-1:0];
        end else begin
          quiet_tmp = (quiet_q == 4'hF) ? quiet_q : quiet_q + 4'd1;
        end
        if (quiet_tmp >= QuietTicks) begin
          acc_d   = '0;
          quiet_d = QuietPark;
        end else begin
          acc_d   = acc_tmp;
          quiet_d = quiet_tmp;
        end
        level_d = LVL_NORMAL;
        if (acc_d > cfg_i.rise_stage_one_limit) level_d = LVL_RISE1;
        if (acc_d > cfg_i.rise_stage_two_limit) level_d = LVL_RISE2;
        if (item_i.average_value <= cfg_i.fixed_heat_limit) level_d = LVL_FIXED;
        if (fault_d) level_d = LVL_FAULT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistD; i++) begin
        hist_q[i] <= '0;
      end
      tick_q  <= '0;
      quiet_q <= '0;
      acc_q   <= '0;
      bad_q   <= '0;
      fault_q <= 1'b0;
      level_q <= LVL_NORMAL;
    end else if (fire_i) begin
      hist_q  <= hist_d;
      tick_q  <= tick_d;
      quiet_q <= quiet_d;
      acc_q   <= acc_d;
      bad_q   <= bad_d;
      fault_q <= fault_d;
      level_q <= level_d;
    end
  end

  assign res_o.alarm_level  = level_d;
  assign res_o.sensor_fault = fault_d;
  assign res_o.rise_total   = acc_d;

endmodule

### rtl/core/heat_rate_of_rise_detector.sv
// channel  | direction | handshake                | payload
// input    | in        | in_valid_i / in_stall_o  | in_item_i  (in_item_t)
// output   | out       | out_valid_o / out_stall_i| out_item_o (out_item_t)
// config   | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// one beat per cycle sustained while the output is not stalled; a result passes through the
// input register, then through evaluation into a two-entry result buffer
// reset clears all detector state and loads the default limits
// input stalls only when the input register is held and both result slots are full
// configuration writes take effect on the next edge

module heat_rate_of_rise_detector import hrr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cfg_t      cfg_q;
  in_item_t  in_q;
  logic      in_vld_q, in_vld_d;
  out_item_t slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  out_item_t res;
  logic      in_acc, adv, pop, full;

  assign full       = cnt_q == 2'd2;
  assign in_stall_o = in_vld_q & full;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign adv        = in_vld_q & ~full;
  assign pop        = out_valid_o & ~out_stall_i;
  assign in_vld_d   = in_acc | (in_vld_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FAULT_LOW:   cfg_q.fault_low_limit      <= cfg_data_i[SampleW-1:0];
        REG_FAULT_HIGH:  cfg_q.fault_high_limit     <= cfg_data_i[SampleW-1:0];
        REG_FAULT_COUNT: cfg_q.fault_count_limit    <= cfg_data_i[7:0];
        REG_RISE_ONE:    cfg_q.rise_stage_one_limit <= cfg_data_i[AccW-1:0];
        REG_RISE_TWO:    cfg_q.rise_stage_two_limit <= cfg_data_i[AccW-1:0];
        REG_FIXED_HEAT:  cfg_q.fixed_heat_limit     <= cfg_data_i[SampleW-1:0];
        REG_PERIOD:      cfg_q.history_period       <= cfg_data_i[3:0];
        REG_MIN_DROP:    cfg_q.minimum_drop         <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_item_i;
    end
  end

  hrr_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (adv),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // two-entry result buffer, slot 0 is the head
  always_comb begin
    cnt_d = cnt_q;
    case ({adv, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (cnt_q == 2'd2) begin
        slot_q[0] <= slot_q[1];
      end else if (adv) begin
        slot_q[0] <= res;
      end
    end else if (adv) begin
      if (cnt_q == 2'd0) begin
        slot_q[0] <= res;
      end else begin
        slot_q[1] <= res;
      end
    end
  end

  assign out_valid_o = cnt_q != 2'd0;
  assign out_item_o  = slot_q[0];

endmodule
